// File: rtl/lrf_pkg.sv
// Shared types, codes and constants of the line rasterizer frame buffer.
package lrf_pkg;

    localparam int DEF_FRAME_WIDTH  = 256;
    localparam int DEF_FRAME_HEIGHT = 144;
    localparam int COORD_W          = 16;  // Q12.4 endpoint width
    localparam int COL_W            = 12;  // column index, holds trunc(32767/16)
    localparam int NUM_W            = 36;  // line numerator, signed
    localparam int DEN_W            = 20;  // 16*|dx|, unsigned
    localparam int INC_W            = 21;  // 16*dy per column, signed
    localparam int WORD_W           = 64;
    localparam int COUNT_W          = 9;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic cap;        // capture command fields
        logic clr;        // write zero at sweep address
        logic rd;         // issue word read
        logic mul;        // register setup products
        logic sum;        // form numerator
        logic div_start;  // launch divider
        logic div_sel;    // 0 numerator, 1 increment
        logic take_n;     // latch start row quotient
        logic take_i;     // latch per-column increment quotient
        logic step;       // advance one column
        logic finish;     // present result
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic vertical;
        logic div_done;
        logic col_end;
    } t_stat;

endpackage

// File: rtl/line_rasterizer_framebuffer.sv
// Top level: one-bit frame buffer with clear, line draw and word read commands.
// Clear writes one word per cycle. A draw forms setup products and runs two divider
// passes, which dominate setup, then steps the columns; a vertical line skips both.
// One command at a time; busy stays high from acceptance until the result strobe.
// Reset (synchronous, active low) starts a clearing sweep of every word of the frame
// memory; busy is high throughout. o_done pulses one cycle; no stall possible.
module line_rasterizer_framebuffer #(
    parameter int FRAME_WIDTH  = lrf_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = lrf_pkg::DEF_FRAME_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_opcode,
    input  logic signed [15:0]          i_start_x,
    input  logic signed [15:0]          i_start_y,
    input  logic signed [15:0]          i_end_x,
    input  logic signed [15:0]          i_end_y,
    input  logic [7:0]                  i_read_row,
    input  logic [1:0]                  i_read_word,
    output logic                        o_done,
    output logic [63:0]                 o_read_data,
    output logic [8:0]                  o_pixels_plotted
);
    // Controller/datapath split: the controller sequences each transaction
    // (a draw: setup multiply, two divider passes, column stepping, flush), the
    // datapath holds the arithmetic, the frame memory and the result registers.
    lrf_pkg::t_cmd  cmd;
    lrf_pkg::t_stat stat;

    lrf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_opcode(i_opcode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Draw: row per column is kept as floor quotient and remainder of the exact
    // line value, stepped incrementally; pixel writes are read-modify-write with
    // forwarding so one column retires per cycle.
    lrf_datapath #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .FRAME_HEIGHT(FRAME_HEIGHT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_opcode        (i_opcode),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_read_row      (i_read_row),
        .i_read_word     (i_read_word),
        .o_stat          (stat),
        .o_read_data     (o_read_data),
        .o_pixels_plotted(o_pixels_plotted),
        .o_done          (o_done)
    );

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted transaction did not raise busy");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result strobe while busy");

endmodule

// File: rtl/lrf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lrf_div #(
    parameter int NUM_W = lrf_pkg::NUM_W,
    parameter int DEN_W = lrf_pkg::DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic [NUM_W-1:0] o_quotient,
    output logic [DEN_W-1:0] o_remainder,
    output logic             o_done
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_div;
    logic             r_done;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;

endmodule

// File: rtl/lrf_ctrl.sv
// Command sequencer of the line rasterizer frame buffer.
module lrf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_opcode,
    input  lrf_pkg::t_stat i_stat,
    output lrf_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    typedef enum logic [10:0] {
        S_INIT  = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_CLEAR = 11'b000_0000_0100,
        S_READ  = 11'b000_0000_1000,
        S_MUL   = 11'b000_0001_0000,
        S_SUM   = 11'b000_0010_0000,
        S_DIVN  = 11'b000_0100_0000,
        S_DIVI  = 11'b000_1000_0000,
        S_DRAW  = 11'b001_0000_0000,
        S_FLUSH = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.cap = 1'b1;
                    unique case (i_opcode)
                        lrf_pkg::OP_CLEAR: n_state = S_CLEAR;
                        lrf_pkg::OP_DRAW:  n_state = S_MUL;
                        lrf_pkg::OP_READ:  n_state = S_READ;
                        default:           n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_DONE;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DONE;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_stat.vertical ? S_DONE : S_SUM;
            end
            S_SUM: begin
                o_cmd.sum       = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVN;
            end
            S_DIVN: begin
                if (i_stat.div_done) begin
                    o_cmd.take_n    = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = 1'b1;
                    n_state         = S_DIVI;
                end
            end
            S_DIVI: begin
                o_cmd.div_sel = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.take_i = 1'b1;
                    n_state      = S_DRAW;
                end
            end
            S_DRAW: begin
                if (i_stat.col_end) n_state = S_FLUSH;
                else                o_cmd.step = 1'b1;
            end
            S_FLUSH: n_state = S_DONE;
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= n_state != S_IDLE;
        end
    end

    assign o_busy = r_busy;

endmodule

// File: rtl/lrf_datapath.sv
// Line setup, column stepping, frame memory and result registers.
module lrf_datapath #(
    parameter int FRAME_WIDTH  = lrf_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = lrf_pkg::DEF_FRAME_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrf_pkg::t_cmd                 i_cmd,
    input  logic [1:0]                    i_opcode,
    input  logic signed [15:0]            i_start_x,
    input  logic signed [15:0]            i_start_y,
    input  logic signed [15:0]            i_end_x,
    input  logic signed [15:0]            i_end_y,
    input  logic [7:0]                    i_read_row,
    input  logic [1:0]                    i_read_word,
    output lrf_pkg::t_stat                o_stat,
    output logic [lrf_pkg::WORD_W-1:0]    o_read_data,
    output logic [lrf_pkg::COUNT_W-1:0]   o_pixels_plotted,
    output logic                          o_done
);
    localparam int NW        = lrf_pkg::NUM_W;
    localparam int DW        = lrf_pkg::DEN_W;
    localparam int IW        = lrf_pkg::INC_W;
    localparam int CW        = lrf_pkg::COL_W;
    localparam int WW        = lrf_pkg::WORD_W;
    localparam int ROW_WORDS = (FRAME_WIDTH + WW - 1) / WW;
    localparam int DEPTH     = FRAME_HEIGHT * ROW_WORDS;
    localparam int AW        = $clog2(DEPTH);
    localparam int RB        = $clog2(FRAME_HEIGHT);

    // captured command
    logic [1:0]         r_op;
    logic signed [15:0] r_ax, r_ay, r_bx, r_by;
    logic [7:0]         r_rrow;
    logic [1:0]         r_rword;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op    <= i_opcode;
            r_ax    <= i_start_x;
            r_ay    <= i_start_y;
            r_bx    <= i_end_x;
            r_by    <= i_end_y;
            r_rrow  <= i_read_row;
            r_rword <= i_read_word;
        end
    end

    // ---------------- setup ----------------
    logic signed [16:0] dx, dy;
    logic signed [15:0] lo, hi;
    logic               swap;
    logic signed [12:0] lo_tr;
    logic [CW-1:0]      i0;
    logic signed [17:0] t0;
    logic [16:0]        absdx;

    assign dx    = 17'(r_bx) - 17'(r_ax);
    assign dy    = 17'(r_by) - 17'(r_ay);
    assign swap  = r_bx > r_ax;
    assign lo    = swap ? r_ax : r_bx;
    assign hi    = swap ? r_bx : r_ax;
    assign lo_tr = $signed({lo[15], lo[15:4]})
                 + $signed({12'd0, lo[15] & (lo[3:0] != 4'd0)});
    assign i0    = lo_tr[12] ? '0 : lo_tr[CW-1:0];
    assign t0    = $signed({2'b00, i0, 4'b0000}) - 18'(r_ax);
    assign absdx = dx[16] ? 17'(-dx) : 17'(dx);

    logic signed [32:0] r_p1;
    logic signed [34:0] r_p2;
    logic               r_neg;
    logic [DW-1:0]      r_den;
    logic signed [IW-1:0] r_inc;
    logic signed [15:0] r_hi;
    logic [CW-1:0]      r_i;
    logic               r_n_neg;

    logic signed [IW-1:0] inc16;
    assign inc16 = {dy, 4'b0000};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p1  <= r_ay * dx;
            r_p2  <= dy * t0;
            r_neg <= dx[16];
            r_den <= {absdx[15:0], 4'b0000};
            r_inc <= dx[16] ? -inc16 : inc16;
            r_hi  <= hi;
        end
    end

    logic signed [NW-1:0] num, nsg;
    logic [NW-1:0]        n_mag, inc_mag;

    assign num     = NW'(r_p1) + NW'(r_p2);
    assign nsg     = r_neg ? -num : num;
    assign n_mag   = nsg[NW-1] ? NW'(-nsg) : NW'(nsg);
    assign inc_mag = r_inc[IW-1] ? NW'(-r_inc) : NW'(r_inc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) r_n_neg <= nsg[NW-1];
    end

    // ---------------- divider ----------------
    logic [NW-1:0] d_q;
    logic [DW-1:0] d_r;
    logic          d_done;

    lrf_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_cmd.div_sel ? inc_mag : n_mag),
        .i_divisor  (r_den),
        .o_quotient (d_q),
        .o_remainder(d_r),
        .o_done     (d_done)
    );

    // floor quotient and nonnegative remainder of a signed dividend
    logic                 f_neg;
    logic signed [NW-1:0] f_q;
    logic [DW-1:0]        f_r;

    assign f_neg = i_cmd.take_i ? r_inc[IW-1] : r_n_neg;

    always_comb begin
        if (!f_neg) begin
            f_q = $signed(d_q);
            f_r = d_r;
        end else if (d_r == '0) begin
            f_q = -$signed(d_q);
            f_r = '0;
        end else begin
            f_q = -$signed(d_q) - NW'(1);
            f_r = r_den - d_r;
        end
    end

    logic signed [NW-1:0] r_q, r_qi;
    logic [DW-1:0]        r_r, r_ri;

    // ---------------- column stepping ----------------
    logic signed [NW-1:0] row_t;
    logic                 plot;
    logic                 col_end;
    logic [AW-1:0]        draw_addr;
    logic [DW:0]          nr;
    logic                 wrap;

    assign row_t     = (r_q[NW-1] && r_r != '0) ? r_q + NW'(1) : r_q;
    assign plot      = !row_t[NW-1] && (row_t < NW'(FRAME_HEIGHT));
    assign col_end   = (r_i >= CW'(FRAME_WIDTH))
                    || ($signed({1'b0, r_i, 4'b0000}) >= 17'(r_hi));
    assign draw_addr = AW'(row_t[RB-1:0]) * AW'(ROW_WORDS) + AW'(r_i[CW-1:6]);
    assign nr        = {1'b0, r_r} + {1'b0, r_ri};
    assign wrap      = nr >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) r_i <= i0;
        else if (i_cmd.step) r_i <= r_i + 1'b1;
        if (i_cmd.take_n) begin
            r_q <= f_q;
            r_r <= f_r;
        end else if (i_cmd.step) begin
            r_q <= r_q + r_qi + NW'(wrap);
            r_r <= wrap ? DW'(nr - {1'b0, r_den}) : nr[DW-1:0];
        end
        if (i_cmd.take_i) begin
            r_qi <= f_q;
            r_ri <= f_r;
        end
    end

    // ---------------- frame memory ----------------
    logic [WW-1:0] mem [DEPTH];
    logic [WW-1:0] r_rdata;
    logic          r_b_valid;
    logic [AW-1:0] r_b_addr;
    logic [5:0]    r_b_bit;
    logic          r_w_valid;
    logic [AW-1:0] r_w_addr;
    logic [WW-1:0] r_w_data;
    logic [AW-1:0] r_clr_cnt;
    logic          clr_last;
    logic          rd_ok;
    logic [AW-1:0] read_addr;
    logic [WW-1:0] wdata;

    assign clr_last  = r_clr_cnt == AW'(DEPTH - 1);
    assign rd_ok     = (32'(r_rrow) < FRAME_HEIGHT) && (32'(r_rword) < ROW_WORDS);
    assign read_addr = AW'(r_rrow) * AW'(ROW_WORDS) + AW'(r_rword);
    // pixel just written may be the word being modified now
    assign wdata     = ((r_w_valid && r_w_addr == r_b_addr) ? r_w_data : r_rdata)
                     | (WW'(1) << r_b_bit);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) mem[r_clr_cnt] <= '0;
        else if (r_b_valid) mem[r_b_addr] <= wdata;
        if (i_cmd.rd) r_rdata <= mem[read_addr];
        else if (i_cmd.step) r_rdata <= mem[draw_addr];
    end

    always_ff @(posedge i_clk) begin
        r_b_addr <= draw_addr;
        r_b_bit  <= r_i[5:0];
        r_w_addr <= r_b_addr;
        r_w_data <= wdata;
    end

    logic [lrf_pkg::COUNT_W-1:0] r_count;
    logic                        r_done;
    logic [WW-1:0]               r_out_data;
    logic [lrf_pkg::COUNT_W-1:0] r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_w_valid <= 1'b0;
            r_clr_cnt <= '0;
            r_count   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_b_valid <= i_cmd.step && plot;
            r_w_valid <= r_b_valid;
            if (i_cmd.cap) r_clr_cnt <= '0;
            else if (i_cmd.clr) r_clr_cnt <= clr_last ? '0 : r_clr_cnt + 1'b1;
            if (i_cmd.cap) r_count <= '0;
            else if (i_cmd.step && plot) r_count <= r_count + 1'b1;
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data  <= (r_op == lrf_pkg::OP_READ && rd_ok) ? r_rdata : '0;
            r_out_count <= (r_op == lrf_pkg::OP_DRAW) ? r_count : '0;
        end
    end

    assign o_stat.clr_last = clr_last;
    assign o_stat.vertical = r_ax == r_bx;
    assign o_stat.div_done = d_done;
    assign o_stat.col_end  = col_end;
    assign o_read_data      = r_out_data;
    assign o_pixels_plotted = r_out_count;
    assign o_done           = r_done;

    a_no_pixel_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr |-> !r_b_valid) else $error("pixel write during clear sweep");
    a_pixel_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> $past(i_cmd.step)) else $error("pixel write without column step");

endmodule

// File: dv/line_rasterizer_framebuffer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the line rasterizer frame buffer.
module line_rasterizer_framebuffer_tb;

    localparam int FRAME_WIDTH  = lrf_pkg::DEF_FRAME_WIDTH;
    localparam int FRAME_HEIGHT = lrf_pkg::DEF_FRAME_HEIGHT;
    localparam int ROW_WORDS    = (FRAME_WIDTH + 63) / 64;
    localparam int RANDOM_CMDS  = 1400;

    localparam logic [1:0] OP_CLEAR = lrf_pkg::OP_CLEAR;
    localparam logic [1:0] OP_DRAW  = lrf_pkg::OP_DRAW;
    localparam logic [1:0] OP_READ  = lrf_pkg::OP_READ;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_opcode;
    logic signed [15:0] i_start_x;
    logic signed [15:0] i_start_y;
    logic signed [15:0] i_end_x;
    logic signed [15:0] i_end_y;
    logic [7:0]         i_read_row;
    logic [1:0]         i_read_word;
    logic               o_done;
    logic [63:0]        o_read_data;
    logic [8:0]         o_pixels_plotted;

    // One command as driven on the ports, plus an optional typed-in answer.
    typedef struct {
        logic [1:0]         op;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic [7:0]         row;
        logic [1:0]         word;
        bit                 has_answer;
        logic [63:0]        answer_data;
        logic [8:0]         answer_count;
    } t_command;

    typedef struct {
        logic [63:0] data;
        logic [8:0]  count;
    } t_answer;

    // Shadow copy of the bitmap, row after row.
    logic [63:0] shadow_frame [FRAME_HEIGHT * ROW_WORDS];
    t_answer     pending_answers [$];
    t_command    directed_rows [$];
    int          error_count = 0;

    line_rasterizer_framebuffer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_start_x        (i_start_x),
        .i_start_y        (i_start_y),
        .i_end_x          (i_end_x),
        .i_end_y          (i_end_y),
        .i_read_row       (i_read_row),
        .i_read_word      (i_read_word),
        .o_done           (o_done),
        .o_read_data      (o_read_data),
        .o_pixels_plotted (o_pixels_plotted)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Rasterize one line into the shadow bitmap, return the pixel count.
    function automatic int rasterize_line(int ax, int ay, int bx, int by);
        int     lo;
        int     hi;
        int     col;
        int     count;
        longint dx;
        longint den;
        longint num;
        longint row;
        count = 0;
        if (ax == bx) return 0;
        lo  = (bx > ax) ? ax : bx;
        hi  = (bx > ax) ? bx : ax;
        dx  = longint'(bx) - longint'(ax);
        den = 16 * dx;
        col = lo / 16;  // truncates toward zero
        if (col < 0) col = 0;  // negative columns clip, never wrap
        for (; col < FRAME_WIDTH && longint'(col) * 16 < longint'(hi); col++) begin
            num = longint'(ay) * dx
                + (longint'(by) - longint'(ay)) * (longint'(col) * 16 - longint'(ax));
            row = num / den;
            if (row >= 0 && row < FRAME_HEIGHT) begin
                shadow_frame[row * ROW_WORDS + col / 64][col % 64] = 1'b1;
                count++;
            end
        end
        return count;
    endfunction

    // Apply one accepted command to the shadow state and form its answer.
    function automatic t_answer predict_command(t_command c);
        t_answer a;
        a.data  = '0;
        a.count = '0;
        case (c.op)
            OP_CLEAR: foreach (shadow_frame[k]) shadow_frame[k] = '0;
            OP_DRAW:  a.count = 9'(rasterize_line(c.sx, c.sy, c.ex, c.ey));
            OP_READ: begin
                if (c.row < FRAME_HEIGHT && c.word < ROW_WORDS)
                    a.data = shadow_frame[c.row * ROW_WORDS + c.word];
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic t_command make_command(logic [1:0] op, int sx, int sy, int ex, int ey,
                                              int row, int word);
        t_command c;
        c.op = op;
        c.sx = 16'(sx);
        c.sy = 16'(sy);
        c.ex = 16'(ex);
        c.ey = 16'(ey);
        c.row = 8'(row);
        c.word = 2'(word);
        c.has_answer = 1'b0;
        c.answer_data = '0;
        c.answer_count = '0;
        return c;
    endfunction

    function automatic void add_row(t_command c, bit typed, logic [63:0] data, logic [8:0] count);
        c.has_answer   = typed;
        c.answer_data  = data;
        c.answer_count = count;
        directed_rows.insert(directed_rows.size(), c);
    endfunction

    // Q12.4 coordinate, pixel part within [lo_px, hi_px], random fraction.
    function automatic int coord_q(int lo_px, int hi_px);
        return (int'($urandom_range(hi_px - lo_px)) + lo_px) * 16 + int'($urandom_range(15));
    endfunction

    function automatic t_command random_command();
        t_command c;
        int       pick;
        pick = $urandom_range(99);
        c = make_command(OP_READ, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(FRAME_HEIGHT - 1), $urandom_range(3));
        if (pick < 3) begin
            c.op = OP_CLEAR;
        end else if (pick < 60) begin
            c.op = OP_DRAW;
            if ($urandom_range(9) != 0) begin
                // Mostly lines near the visible frame, so pixels land.
                c.sx = 16'(coord_q(-20, FRAME_WIDTH + 20));
                c.ex = 16'(coord_q(-20, FRAME_WIDTH + 20));
                c.sy = 16'(coord_q(-10, FRAME_HEIGHT + 10));
                c.ey = 16'(coord_q(-10, FRAME_HEIGHT + 10));
                if ($urandom_range(19) == 0) c.ex = c.sx;  // vertical
            end
        end
        return c;
    endfunction

    // Result checker: compare every strobed result to the oldest expectation.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_done) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result data=%h count=%0d",
                         $time, o_read_data, o_pixels_plotted);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_read_data !== want.data) begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.data, o_read_data);
                    error_count++;
                end
                if (o_pixels_plotted !== want.count) begin
                    $display("%0t: pixels_plotted expected %0d actual %0d",
                             $time, want.count, o_pixels_plotted);
                    error_count++;
                end
            end
        end
    end

    // Present one command and hold it until the transaction is accepted.
    task automatic issue_command(t_command c);
        t_answer a;
        i_opcode    = c.op;
        i_start_x   = c.sx;
        i_start_y   = c.sy;
        i_end_x     = c.ex;
        i_end_y     = c.ey;
        i_read_row  = c.row;
        i_read_word = c.word;
        start       = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        a = predict_command(c);
        if (c.has_answer && (a.data !== c.answer_data || a.count !== c.answer_count)) begin
            // A typed-in answer disagreeing with the shadow model is a bench error too.
            $display("%0t: table answer expected %h/%0d predicted %h/%0d",
                     $time, c.answer_data, c.answer_count, a.data, a.count);
            error_count++;
        end
        if (c.has_answer) begin
            a.data  = c.answer_data;
            a.count = c.answer_count;
        end
        pending_answers.insert(pending_answers.size(), a);
        @(negedge i_clk);
        // Random gap before the next command: mostly none, sometimes long.
        if ($urandom_range(3) == 0) begin
            start = 1'b0;
            repeat (($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
                @(negedge i_clk);
        end
    endtask

    initial begin
        int waited;
        foreach (shadow_frame[k]) shadow_frame[k] = '0;
        start = 1'b0;
        i_rst_n = 1'b0;
        i_opcode = OP_READ;
        i_start_x = '0;
        i_start_y = '0;
        i_end_x = '0;
        i_end_y = '0;
        i_read_row = '0;
        i_read_word = '0;

        // Directed table: typed answers where obvious, predictor elsewhere.
        add_row(make_command(OP_READ, 0, 0, 0, 0, 0, 0), 1, '0, '0);        // after reset
        add_row(make_command(OP_READ, 0, 0, 0, 0, 143, 3), 1, '0, '0);      // last word
        add_row(make_command(OP_READ, 0, 0, 0, 0, 200, 1), 1, '0, '0);      // row beyond frame
        add_row(make_command(OP_DRAW, 800, 0, 800, 2000, 0, 0), 1, '0, '0); // vertical line
        add_row(make_command(OP_DRAW, 0, 0, 4096, 0, 0, 0), 1, '0, 9'd256); // full row 0
        add_row(make_command(OP_READ, 0, 0, 0, 0, 0, 3), 1, '1, '0);
        add_row(make_command(OP_DRAW, 0, 0, 4096, 0, 0, 0), 1, '0, 9'd256); // already set
        add_row(make_command(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1, '0, '0);
        add_row(make_command(OP_READ, 0, 0, 0, 0, 0, 0), 1, '0, '0);
        add_row(make_command(OP_DRAW, -32768, 32, 32767, 48, 0, 0), 0, '0, '0); // negative cols
        add_row(make_command(OP_READ, 0, 0, 0, 0, 2, 0), 0, '0, '0);
        add_row(make_command(OP_DRAW, 0, -8, 1000, -8, 0, 0), 0, '0, '0);   // row just above zero
        add_row(make_command(OP_READ, 0, 0, 0, 0, 0, 0), 0, '0, '0);
        add_row(make_command(OP_DRAW, -32768, -32768, 32767, 32767, 0, 0), 0, '0, '0);
        add_row(make_command(OP_DRAW, 32767, -32768, -32768, 32767, 0, 0), 0, '0, '0);
        add_row(make_command(OP_DRAW, 0, 2303, 4095, 0, 0, 0), 0, '0, '0);  // corner-to-corner diagonal
        add_row(make_command(OP_DRAW, 4095, 0, -100, 2303, 0, 0), 0, '0, '0);
        add_row(make_command(OP_READ, 0, 0, 0, 0, 143, 0), 0, '0, '0);
        add_row(make_command(OP_READ, 0, 0, 0, 0, 71, 2), 0, '0, '0);
        add_row(make_command(OP_READ, 0, 0, 0, 0, 1, 1), 0, '0, '0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k]) issue_command(directed_rows[k]);

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n == RANDOM_CMDS / 2) begin
                // Hold off until the block has drained every outstanding result.
                start = 1'b0;
                while (pending_answers.size() != 0) @(negedge i_clk);
            end
            issue_command(random_command());
        end
        start = 1'b0;

        waited = 0;
        while (pending_answers.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_answers.size() == 0) begin
            $display("[line_rasterizer_framebuffer] OK");
        end else begin
            if (pending_answers.size() != 0)
                $display("%0t: %0d results never arrived", $time, pending_answers.size());
            $display("[line_rasterizer_framebuffer] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #40ms;
        $display("%0t: timeout", $time);
        $display("[line_rasterizer_framebuffer] ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/lrf_pkg.sv
rtl/lrf_div.sv
rtl/lrf_ctrl.sv
rtl/lrf_datapath.sv
rtl/line_rasterizer_framebuffer.sv
dv/line_rasterizer_framebuffer_tb.sv
